// ===== src/dsm_pkg.sv =====
// shared types and codes for the dfa state minimizer
package dsm_pkg;

	// command codes on the operation field
	typedef enum logic [1:0] {
		OP_LOAD  = 2'd0,
		OP_FLAG  = 2'd1,
		OP_RUN   = 2'd2,
		OP_READ  = 2'd3
	} op_t;

	// result kinds
	typedef enum logic {
		KIND_RUN  = 1'b0,
		KIND_READ = 1'b1
	} kind_t;

	// configuration register indexes
	localparam logic REG_STATE_COUNT  = 1'b0;
	localparam logic REG_SYMBOL_COUNT = 1'b1;

	// sequencer states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_INIT_F0,
		ST_INIT_RD,
		ST_INIT_WR,
		ST_RND,
		ST_I,
		ST_R,
		ST_L,
		ST_C0,
		ST_T,
		ST_TC,
		ST_TK,
		ST_NEXTI,
		ST_CP_RD,
		ST_CP_WR,
		ST_CHK
	} seq_t;

endpackage

// ===== src/dfa_state_minimizer.sv =====
// dfa state minimizer: table storage, moore refinement sequencer and class readout
// load and flag transactions are written directly and give no result; busy stays low.
// read transactions are taken one per cycle while busy is low; the result strobe comes in the next cycle.
// a run walks the transition memory symbol by symbol through states T, TC and TK for each state against
//   each candidate leader, plus a per-state copy pass per round; busy is high throughout.
// asynchronous reset clears accepting flag valid bits, class count and the sequencer; memories keep data.
// results cannot be held off by the receiver.
module dfa_state_minimizer #(
	parameter int MAX_STATES  = 256,
	parameter int MAX_SYMBOLS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	// command channel
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  operation,
	input  logic [7:0]  state_index,
	input  logic [5:0]  symbol_index,
	input  logic [7:0]  target_state,
	input  logic        accepting,
	// result channel
	output logic        done,
	output logic        result_kind,
	output logic [8:0]  class_count,
	output logic [7:0]  state_class,
	// configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int SW  = $clog2(MAX_STATES);
	localparam int CW  = SW + 1;
	localparam int MCW = $clog2(MAX_SYMBOLS + 1);
	localparam int TAW = $clog2(MAX_STATES * MAX_SYMBOLS);
	localparam int TD  = MAX_STATES * MAX_SYMBOLS;

	localparam logic REG_SEL_SYM = dsm_pkg::REG_SYMBOL_COUNT;

	// memories
	logic [7:0]    trans_mem [TD];
	logic          acc_mem   [MAX_STATES];
	logic [SW-1:0] cur_mem   [MAX_STATES];
	logic [SW-1:0] next_mem  [MAX_STATES];
	logic [SW-1:0] lead_mem  [MAX_STATES];

	logic [MAX_STATES-1:0] acc_vld_q;

	// configuration registers
	logic [8:0] state_count_q;
	logic [6:0] symbol_count_q;

	// sequencer
	dsm_pkg::seq_t state_q, state_d;
	logic [CW-1:0]  n_q, i_q, k_q, r_q, prev_q, classes_q, covered_q;
	logic [MCW-1:0] m_q, s_q;
	logic [SW-1:0]  lead_q;
	logic           first_q;

	// read data
	logic [7:0]    trans_rd_a, trans_rd_b;
	logic          acc_rd;
	logic [SW-1:0] acc_addr_s1;
	logic [SW-1:0] cur_rd_a, cur_rd_b;
	logic [SW-1:0] next_rd, lead_rd;
	logic          qv_s1, qin_s1;

	// addresses and controls
	logic [TAW-1:0] trans_ra, trans_rb, trans_wa;
	logic [SW-1:0]  cur_ra, cur_rb, acc_ra;
	logic [SW-1:0]  tgt_a, tgt_b, st_i;
	logic           cmd_ok, st_ok, sym_ok;
	logic           run_go, cur_eq, r_at_k, last_sym, last_i, flag_now, stop_now;
	logic [CW-1:0]  n_clamp;
	logic [MCW-1:0] m_clamp;

	// command decode
	assign cmd_ok = start && !busy;
	assign st_ok  = 32'(state_index) < MAX_STATES;
	assign sym_ok = 32'(symbol_index) < MAX_SYMBOLS;
	assign st_i   = SW'(state_index);
	assign run_go = cmd_ok && (dsm_pkg::op_t'(operation) == dsm_pkg::OP_RUN);
	assign trans_wa = TAW'(32'(st_i) * MAX_SYMBOLS + 32'(symbol_index));

	// clamped register values
	always_comb begin
		if (state_count_q == 9'd0) begin
			n_clamp = CW'(1);
		end else if (32'(state_count_q) > MAX_STATES) begin
			n_clamp = CW'(MAX_STATES);
		end else begin
			n_clamp = CW'(state_count_q);
		end
		if (symbol_count_q == 7'd0) begin
			m_clamp = MCW'(1);
		end else if (32'(symbol_count_q) > MAX_SYMBOLS) begin
			m_clamp = MCW'(MAX_SYMBOLS);
		end else begin
			m_clamp = MCW'(symbol_count_q);
		end
	end

	// target clamp to the last state in use
	assign tgt_a = (32'(trans_rd_a) >= 32'(n_q)) ? SW'(n_q - CW'(1)) : SW'(trans_rd_a);
	assign tgt_b = (32'(trans_rd_b) >= 32'(n_q)) ? SW'(n_q - CW'(1)) : SW'(trans_rd_b);

	// comparisons
	assign cur_eq   = cur_rd_a == cur_rd_b;
	assign r_at_k   = r_q == k_q;
	assign last_sym = (32'(s_q) + 1) == 32'(m_q);
	assign last_i   = (32'(i_q) + 1) == 32'(n_q);
	assign flag_now = acc_rd & acc_vld_q[acc_addr_s1];
	assign stop_now = k_q == prev_q;

	// read address selection
	always_comb begin
		trans_ra = TAW'(32'(lead_q) * MAX_SYMBOLS + 32'(s_q));
		trans_rb = TAW'(32'(i_q[SW-1:0]) * MAX_SYMBOLS + 32'(s_q));
		acc_ra   = (state_q == dsm_pkg::ST_IDLE) ? '0 : i_q[SW-1:0];
		unique case (state_q)
			dsm_pkg::ST_L: begin
				cur_ra = lead_rd;
				cur_rb = i_q[SW-1:0];
			end
			dsm_pkg::ST_TC: begin
				cur_ra = tgt_a;
				cur_rb = tgt_b;
			end
			default: begin
				cur_ra = st_i;
				cur_rb = i_q[SW-1:0];
			end
		endcase
	end

	// transition memory
	always_ff @(posedge clk) begin
		if (cmd_ok && dsm_pkg::op_t'(operation) == dsm_pkg::OP_LOAD && st_ok && sym_ok) begin
			trans_mem[trans_wa] <= target_state;
		end
		trans_rd_a <= trans_mem[trans_ra];
		trans_rd_b <= trans_mem[trans_rb];
	end

	// accepting flag memory
	always_ff @(posedge clk) begin
		if (cmd_ok && dsm_pkg::op_t'(operation) == dsm_pkg::OP_FLAG && st_ok) begin
			acc_mem[st_i] <= accepting;
		end
		acc_rd      <= acc_mem[acc_ra];
		acc_addr_s1 <= acc_ra;
	end

	// accepting flag valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_vld_q <= '0;
		end else if (cmd_ok && dsm_pkg::op_t'(operation) == dsm_pkg::OP_FLAG && st_ok) begin
			acc_vld_q[st_i] <= 1'b1;
		end
	end

	// current class memory
	always_ff @(posedge clk) begin
		if (state_q == dsm_pkg::ST_INIT_WR) begin
			cur_mem[i_q[SW-1:0]] <= (flag_now != first_q) ? SW'(1) : '0;
		end else if (state_q == dsm_pkg::ST_CP_WR) begin
			cur_mem[i_q[SW-1:0]] <= next_rd;
		end
		cur_rd_a <= cur_mem[cur_ra];
		cur_rd_b <= cur_mem[cur_rb];
	end

	// working class memory
	always_ff @(posedge clk) begin
		if (state_q == dsm_pkg::ST_R && r_at_k) begin
			next_mem[i_q[SW-1:0]] <= k_q[SW-1:0];
		end else if (state_q == dsm_pkg::ST_TK && cur_eq && last_sym) begin
			next_mem[i_q[SW-1:0]] <= r_q[SW-1:0];
		end
		next_rd <= next_mem[i_q[SW-1:0]];
	end

	// leader memory
	always_ff @(posedge clk) begin
		if (state_q == dsm_pkg::ST_R && r_at_k) begin
			lead_mem[k_q[SW-1:0]] <= i_q[SW-1:0];
		end
		lead_rd <= lead_mem[r_q[SW-1:0]];
	end

	// sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dsm_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			dsm_pkg::ST_IDLE:    if (run_go) state_d = dsm_pkg::ST_INIT_F0;
			dsm_pkg::ST_INIT_F0: state_d = dsm_pkg::ST_INIT_RD;
			dsm_pkg::ST_INIT_RD: state_d = dsm_pkg::ST_INIT_WR;
			dsm_pkg::ST_INIT_WR: state_d = last_i ? dsm_pkg::ST_RND : dsm_pkg::ST_INIT_RD;
			dsm_pkg::ST_RND:     state_d = dsm_pkg::ST_I;
			dsm_pkg::ST_I:       state_d = dsm_pkg::ST_R;
			dsm_pkg::ST_R:       state_d = r_at_k ? dsm_pkg::ST_NEXTI : dsm_pkg::ST_L;
			dsm_pkg::ST_L:       state_d = dsm_pkg::ST_C0;
			dsm_pkg::ST_C0:      state_d = cur_eq ? dsm_pkg::ST_T : dsm_pkg::ST_R;
			dsm_pkg::ST_T:       state_d = dsm_pkg::ST_TC;
			dsm_pkg::ST_TC:      state_d = dsm_pkg::ST_TK;
			dsm_pkg::ST_TK: begin
				if (!cur_eq) begin
					state_d = dsm_pkg::ST_R;
				end else if (last_sym) begin
					state_d = dsm_pkg::ST_NEXTI;
				end else begin
					state_d = dsm_pkg::ST_T;
				end
			end
			dsm_pkg::ST_NEXTI:   state_d = last_i ? dsm_pkg::ST_CP_RD : dsm_pkg::ST_I;
			dsm_pkg::ST_CP_RD:   state_d = dsm_pkg::ST_CP_WR;
			dsm_pkg::ST_CP_WR:   state_d = last_i ? dsm_pkg::ST_CHK : dsm_pkg::ST_CP_RD;
			dsm_pkg::ST_CHK:     state_d = stop_now ? dsm_pkg::ST_IDLE : dsm_pkg::ST_RND;
			default:             state_d = dsm_pkg::ST_IDLE;
		endcase
	end

	// sequencer counters and run results
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q       <= CW'(1);
			m_q       <= MCW'(1);
			i_q       <= '0;
			k_q       <= '0;
			r_q       <= '0;
			s_q       <= '0;
			prev_q    <= CW'(1);
			lead_q    <= '0;
			first_q   <= 1'b0;
			classes_q <= '0;
			covered_q <= '0;
		end else begin
			unique case (state_q)
				dsm_pkg::ST_IDLE: begin
					if (run_go) begin
						n_q    <= n_clamp;
						m_q    <= m_clamp;
						prev_q <= CW'(1);
					end
				end
				dsm_pkg::ST_INIT_F0: begin
					first_q <= flag_now;
					i_q     <= '0;
				end
				dsm_pkg::ST_INIT_WR: begin
					if (flag_now != first_q) prev_q <= CW'(2);
					i_q <= last_i ? '0 : i_q + CW'(1);
				end
				dsm_pkg::ST_RND: begin
					i_q <= '0;
					k_q <= '0;
				end
				dsm_pkg::ST_I: r_q <= '0;
				dsm_pkg::ST_R: if (r_at_k) k_q <= k_q + CW'(1);
				dsm_pkg::ST_L: lead_q <= lead_rd;
				dsm_pkg::ST_C0: begin
					s_q <= '0;
					if (!cur_eq) r_q <= r_q + CW'(1);
				end
				dsm_pkg::ST_TK: begin
					if (!cur_eq) begin
						r_q <= r_q + CW'(1);
					end else if (!last_sym) begin
						s_q <= s_q + MCW'(1);
					end
				end
				dsm_pkg::ST_NEXTI: i_q <= last_i ? '0 : i_q + CW'(1);
				dsm_pkg::ST_CP_WR: i_q <= last_i ? '0 : i_q + CW'(1);
				dsm_pkg::ST_CHK: begin
					prev_q <= k_q;
					if (stop_now) begin
						classes_q <= k_q;
						covered_q <= n_q;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// read transaction pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qv_s1  <= 1'b0;
			qin_s1 <= 1'b0;
		end else begin
			qv_s1  <= cmd_ok && (dsm_pkg::op_t'(operation) == dsm_pkg::OP_READ);
			qin_s1 <= st_ok && (32'(state_index) < 32'(covered_q));
		end
	end

	// result drive
	assign busy        = state_q != dsm_pkg::ST_IDLE;
	assign done        = qv_s1 || (state_q == dsm_pkg::ST_CHK && stop_now);
	assign result_kind = qv_s1 ? dsm_pkg::KIND_READ : dsm_pkg::KIND_RUN;
	assign class_count = qv_s1 ? 9'(classes_q) : 9'(k_q);
	assign state_class = (qv_s1 && qin_s1) ? 8'(cur_rd_a) : 8'd0;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_count_q  <= 9'd1;
			symbol_count_q <= 7'd1;
		end else if (psel && penable && pwrite) begin
			if (paddr[2] == REG_SEL_SYM) begin
				symbol_count_q <= pwdata[6:0];
			end else begin
				state_count_q <= pwdata[8:0];
			end
		end
	end

	assign prdata = (paddr[2] == REG_SEL_SYM) ? 32'(symbol_count_q) : 32'(state_count_q);
	assign pready = 1'b1;

endmodule
